FILE: hw/rtl/s2x_pkg.sv
// Shared constants, codes and types of the 2x pixel upscaler.
`timescale 1ns / 1ps

package s2x_pkg;

    // Parameter defaults.
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int PIXEL_BITS_DEF = 32;

    // Register reset values, in pixels and rows.
    localparam int WIDTH_RESET  = 320;
    localparam int HEIGHT_RESET = 240;

    // Fixed port widths.
    localparam int PORT_PIX_W = 32;
    localparam int COL_PORT_W = 11;
    localparam int ROW_W      = 16;
    localparam int CFG_WIDTH_BITS = 12;
    localparam int CFG_DATA_W = 16;

    // Job queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QLW    = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_cfg_reg;

    // Blocks a pixel can release, in emission order; the value is its bit in t_job_flags.blocks.
    typedef enum logic [1:0] {
        BLK_UP_MID   = 2'd0,   // row above, column to the left
        BLK_UP_END   = 2'd1,   // row above, last column
        BLK_LAST_MID = 2'd2,   // last row, column to the left
        BLK_LAST_END = 2'd3    // last row, last column
    } t_blk;

    // Pixel slots carried in one job.
    localparam int NPX    = 8;
    localparam int PX_IN  = 0;  // incoming pixel
    localparam int PX_R0  = 1;  // row above, col-2
    localparam int PX_R1  = 2;  // row above, col-1
    localparam int PX_R2  = 3;  // input row, col-2
    localparam int PX_R3  = 4;  // input row, col-1
    localparam int PX_MID = 5;  // row above, col
    localparam int PX_UP  = 6;  // two rows above, col-1
    localparam int PX_UC  = 7;  // two rows above, col

    typedef struct packed {
        logic [3:0] blocks;
        logic       col_zero;
        logic       col_one;
        logic       row_zero;
        logic       row_one;
    } t_job_flags;

endpackage

FILE: hw/rtl/s2x_front.sv
// Front part: accept pixels, keep the line stores and the recent pixels, classify each pixel.
`timescale 1ns / 1ps

module s2x_front import s2x_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [PORT_PIX_W-1:0]            i_pixel,
    output logic                             o_stall,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_index,
    input  logic [CFG_DATA_W-1:0]            i_cfg_data,
    output logic                             o_cfg_ready,
    input  logic [QLW-1:0]                   i_q_level,
    output logic                             o_job_valid,
    output logic [NPX-1:0][PIXEL_BITS-1:0]   o_job_px,
    output logic [CW-1:0]                    o_job_col,
    output logic [ROW_W-1:0]                 o_job_row,
    output t_job_flags                       o_job_flags
);

    localparam logic [CW-1:0] LAST_COL_MAX = CW'(MAX_WIDTH - 1);
    localparam logic [CW-1:0] LAST_COL_RST =
        CW'(((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET) - 1);
    localparam logic [ROW_W-1:0] LAST_ROW_RST = ROW_W'(HEIGHT_RESET - 1);
    localparam logic [31:0] MAX_WIDTH_W = 32'(MAX_WIDTH);

    logic [CW-1:0]    r_last_col, n_last_col;
    logic [ROW_W-1:0] r_last_row, n_last_row;
    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic                  r_s1_valid;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic [CW-1:0]         r_s1_col;
    logic [ROW_W-1:0]      r_s1_row;
    logic                  r_s1_row_end;
    logic                  r_s1_last_row;

    logic [2*PIXEL_BITS-1:0] mem [MAX_WIDTH];
    logic [2*PIXEL_BITS-1:0] r_rd;
    logic                    r_byp;
    logic [2*PIXEL_BITS-1:0] r_byp_data;

    logic [PIXEL_BITS-1:0] r_rc [4];
    logic [PIXEL_BITS-1:0] r_up;

    logic [CFG_WIDTH_BITS-1:0] cfg_w;
    logic                      accept;
    logic                      outside;
    logic [CW-1:0]             cur_col;
    logic [ROW_W-1:0]          cur_row;
    logic                      row_end;
    logic                      last_row;
    logic [2*PIXEL_BITS-1:0]   rd;
    logic [PIXEL_BITS-1:0]     rd_mid;
    logic [PIXEL_BITS-1:0]     rd_uc;
    logic [2*PIXEL_BITS-1:0]   wr_data;

    assign o_cfg_ready = 1'b1;
    assign cfg_w       = i_cfg_data[CFG_WIDTH_BITS-1:0];

    // Credit check: the pixel in stage one may still need a queue slot.
    assign o_stall = ({1'b0, i_q_level} + (QLW+1)'(r_s1_valid)) >= (QLW+1)'(QDEPTH);
    assign accept  = i_valid && !o_stall;

    // Clamp register values into last indexes at write time.
    always_comb begin
        n_last_col = r_last_col;
        n_last_row = r_last_row;
        if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_WIDTH: begin
                    priority if (cfg_w == '0) begin
                        n_last_col = '0;
                    end else if (32'(cfg_w) > MAX_WIDTH_W) begin
                        n_last_col = LAST_COL_MAX;
                    end else begin
                        n_last_col = CW'(cfg_w - CFG_WIDTH_BITS'(1));
                    end
                end
                REG_HEIGHT: begin
                    n_last_row = (i_cfg_data == '0) ? '0 : i_cfg_data - ROW_W'(1);
                end
            endcase
        end
    end

    // Position of the incoming pixel; a shrunken frame restarts at the origin.
    assign outside  = (r_col > r_last_col) || (r_row > r_last_row);
    assign cur_col  = outside ? '0 : r_col;
    assign cur_row  = outside ? '0 : r_row;
    assign row_end  = (cur_col == r_last_col);
    assign last_row = (cur_row == r_last_row);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (row_end) begin
                n_col = '0;
                n_row = last_row ? '0 : cur_row + ROW_W'(1);
            end else begin
                n_col = cur_col + CW'(1);
                n_row = cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col <= LAST_COL_RST;
            r_last_row <= LAST_ROW_RST;
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_rc[i] <= '0;
            end
        end else begin
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= accept;
            if (r_s1_valid) begin
                r_rc[0] <= r_rc[1];
                r_rc[1] <= rd_mid;
                r_rc[2] <= r_rc[3];
                r_rc[3] <= r_s1_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix      <= i_pixel[PIXEL_BITS-1:0];
            r_s1_col      <= cur_col;
            r_s1_row      <= cur_row;
            r_s1_row_end  <= row_end;
            r_s1_last_row <= last_row;
        end
        if (r_s1_valid) begin
            r_up <= rd_uc;
        end
    end

    // Line store entry: {two rows above, one row above}; shift a row down on each write.
    assign rd      = r_byp ? r_byp_data : r_rd;
    assign rd_mid  = rd[PIXEL_BITS-1:0];
    assign rd_uc   = rd[2*PIXEL_BITS-1:PIXEL_BITS];
    assign wr_data = {rd_mid, r_s1_pix};

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem[r_s1_col] <= wr_data;
        end
        if (accept) begin
            r_rd <= mem[cur_col];
        end
    end

    // Forward the write when a one-pixel row reads the entry written in the same cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byp      <= r_s1_valid && (cur_col == r_s1_col);
            r_byp_data <= wr_data;
        end
    end

    always_comb begin
        o_job_flags = '0;
        o_job_flags.blocks[BLK_UP_MID]   = (r_s1_row != '0) && (r_s1_col != '0);
        o_job_flags.blocks[BLK_UP_END]   = (r_s1_row != '0) && r_s1_row_end;
        o_job_flags.blocks[BLK_LAST_MID] = r_s1_last_row && (r_s1_col != '0);
        o_job_flags.blocks[BLK_LAST_END] = r_s1_last_row && r_s1_row_end;
        o_job_flags.col_zero = (r_s1_col == '0);
        o_job_flags.col_one  = (r_s1_col == CW'(1));
        o_job_flags.row_zero = (r_s1_row == '0);
        o_job_flags.row_one  = (r_s1_row == ROW_W'(1));
    end

    assign o_job_valid = r_s1_valid && (o_job_flags.blocks != '0);
    assign o_job_col   = r_s1_col;
    assign o_job_row   = r_s1_row;

    always_comb begin
        o_job_px         = '0;
        o_job_px[PX_IN]  = r_s1_pix;
        o_job_px[PX_R0]  = r_rc[0];
        o_job_px[PX_R1]  = r_rc[1];
        o_job_px[PX_R2]  = r_rc[2];
        o_job_px[PX_R3]  = r_rc[3];
        o_job_px[PX_MID] = rd_mid;
        o_job_px[PX_UP]  = r_up;
        o_job_px[PX_UC]  = rd_uc;
    end

endmodule

FILE: hw/rtl/s2x_queue.sv
// Short job queue between the front and the back.
`timescale 1ns / 1ps

module s2x_queue import s2x_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    output logic [QLW-1:0]   o_level
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam logic [PW-1:0] LAST_SLOT = PW'(QDEPTH - 1);

    logic [WIDTH-1:0] r_mem [QDEPTH];
    logic [PW-1:0]    r_head, n_head;
    logic [PW-1:0]    r_tail, n_tail;
    logic [QLW-1:0]   r_level, n_level;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_level = r_level;
        if (i_push) begin
            n_tail  = (r_tail == LAST_SLOT) ? '0 : r_tail + PW'(1);
            n_level = n_level + QLW'(1);
        end
        if (i_pop) begin
            n_head  = (r_head == LAST_SLOT) ? '0 : r_head + PW'(1);
            n_level = n_level - QLW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_level <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_head];
    assign o_level = r_level;

endmodule

FILE: hw/rtl/s2x_back.sv
// Back: build each job's 2x2 blocks, one per unstalled cycle, into the output register.
`timescale 1ns / 1ps

module s2x_back import s2x_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_job_valid,
    input  logic [NPX-1:0][PIXEL_BITS-1:0] i_job_px,
    input  logic [CW-1:0]                  i_job_col,
    input  logic [ROW_W-1:0]               i_job_row,
    input  t_job_flags                     i_job_flags,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [PORT_PIX_W-1:0]          o_top_left,
    output logic [PORT_PIX_W-1:0]          o_top_right,
    output logic [PORT_PIX_W-1:0]          o_bottom_left,
    output logic [PORT_PIX_W-1:0]          o_bottom_right,
    output logic [COL_PORT_W-1:0]          o_out_col,
    output logic [ROW_W-1:0]               o_out_row,
    output logic                           o_last_of_run,
    output logic                           o_frame_done
);

    logic [3:0]            r_done;
    logic                  r_ovalid;
    logic [PIXEL_BITS-1:0] r_tl, r_tr, r_bl, r_br;
    logic [CW-1:0]         r_col;
    logic [ROW_W-1:0]      r_row;
    logic                  r_last;
    logic                  r_fdone;

    logic [3:0]            rem;
    t_blk                  sel;
    logic [3:0]            sel_bit;
    logic                  last;
    logic                  load;
    logic [PIXEL_BITS-1:0] pb, pd, pe, pf, ph;
    logic [PIXEL_BITS-1:0] tl, tr, bl, br;
    logic [CW-1:0]         bcol;
    logic [ROW_W-1:0]      brow;
    logic                  fdone;

    // Next block still owed by the job at the head of the queue.
    assign rem = i_job_flags.blocks & ~r_done;

    always_comb begin
        priority if (rem[BLK_UP_MID]) begin
            sel = BLK_UP_MID;
        end else if (rem[BLK_UP_END]) begin
            sel = BLK_UP_END;
        end else if (rem[BLK_LAST_MID]) begin
            sel = BLK_LAST_MID;
        end else begin
            sel = BLK_LAST_END;
        end
    end

    assign sel_bit = 4'b0001 << sel;
    assign last    = (rem & ~sel_bit) == '0;
    assign load    = i_job_valid && (!r_ovalid || !i_stall);
    assign o_pop   = load && last;

    // Gather the centre and its neighbors; an edge neighbor takes the centre.
    always_comb begin
        unique case (sel)
            BLK_UP_MID: begin
                pe    = i_job_px[PX_R1];
                pd    = i_job_flags.col_one ? pe : i_job_px[PX_R0];
                pb    = i_job_flags.row_one ? pe : i_job_px[PX_UP];
                pf    = i_job_px[PX_MID];
                ph    = i_job_px[PX_R3];
                bcol  = i_job_col - CW'(1);
                brow  = i_job_row - ROW_W'(1);
                fdone = 1'b0;
            end
            BLK_UP_END: begin
                pe    = i_job_px[PX_MID];
                pd    = i_job_flags.col_zero ? pe : i_job_px[PX_R1];
                pb    = i_job_flags.row_one ? pe : i_job_px[PX_UC];
                pf    = pe;
                ph    = i_job_px[PX_IN];
                bcol  = i_job_col;
                brow  = i_job_row - ROW_W'(1);
                fdone = 1'b0;
            end
            BLK_LAST_MID: begin
                pe    = i_job_px[PX_R3];
                pd    = i_job_flags.col_one ? pe : i_job_px[PX_R2];
                pb    = i_job_flags.row_zero ? pe : i_job_px[PX_R1];
                pf    = i_job_px[PX_IN];
                ph    = pe;
                bcol  = i_job_col - CW'(1);
                brow  = i_job_row;
                fdone = 1'b0;
            end
            BLK_LAST_END: begin
                pe    = i_job_px[PX_IN];
                pd    = i_job_flags.col_zero ? pe : i_job_px[PX_R3];
                pb    = i_job_flags.row_zero ? pe : i_job_px[PX_MID];
                pf    = pe;
                ph    = pe;
                bcol  = i_job_col;
                brow  = i_job_row;
                fdone = 1'b1;
            end
        endcase
    end

    // Corner rule.
    always_comb begin
        tl = pe;
        tr = pe;
        bl = pe;
        br = pe;
        if ((pb != ph) && (pd != pf)) begin
            tl = (pd == pb) ? pd : pe;
            tr = (pf == pb) ? pf : pe;
            bl = (pd == ph) ? pd : pe;
            br = (pf == ph) ? pf : pe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_done   <= '0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (o_pop) begin
                r_done <= '0;
            end else if (load) begin
                r_done <= r_done | sel_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tl    <= tl;
            r_tr    <= tr;
            r_bl    <= bl;
            r_br    <= br;
            r_col   <= bcol;
            r_row   <= brow;
            r_last  <= last;
            r_fdone <= fdone;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_top_left     = PORT_PIX_W'(r_tl);
    assign o_top_right    = PORT_PIX_W'(r_tr);
    assign o_bottom_left  = PORT_PIX_W'(r_bl);
    assign o_bottom_right = PORT_PIX_W'(r_br);
    assign o_out_col      = COL_PORT_W'(r_col);
    assign o_out_row      = r_row;
    assign o_last_of_run  = r_last;
    assign o_frame_done   = r_fdone;

endmodule

FILE: hw/rtl/scale2x_pixel_upscaler.sv
// Top level of the streaming 2x pixel upscaler: front, job queue and back.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Word
// --------  ---------  ------------------------  ---------------------------------------
// pixel in  input      i_valid / o_stall         i_pixel
// block out output     o_valid / i_stall         four corners, column, row, run/frame flags
// config    input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Take one pixel per clock while the job queue has credit. A pixel releases at most one
// block inside a row, two on the last row or at a row end, four at the frame's last pixel.
// Deliver one block per clock from the output register while i_stall is low; extra blocks
// stall the input. Blocks trail their centre by one row and one pixel, except at a row end
// or on the last row. Reset is synchronous. Stall the input once the four queue entries
// are taken or promised to the front stage.

module scale2x_pixel_upscaler import s2x_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PORT_PIX_W-1:0] i_pixel,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PORT_PIX_W-1:0] o_top_left,
    output logic [PORT_PIX_W-1:0] o_top_right,
    output logic [PORT_PIX_W-1:0] o_bottom_left,
    output logic [PORT_PIX_W-1:0] o_bottom_right,
    output logic [COL_PORT_W-1:0] o_out_col,
    output logic [ROW_W-1:0]      o_out_row,
    output logic                  o_last_of_run,
    output logic                  o_frame_done,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int FW = $bits(t_job_flags);
    localparam int PXW = NPX * PIXEL_BITS;
    localparam int QW = PXW + CW + ROW_W + FW;

    // Job from the front, as pushed into the queue.
    logic                           f_valid;
    logic [NPX-1:0][PIXEL_BITS-1:0] f_px;
    logic [CW-1:0]                  f_col;
    logic [ROW_W-1:0]               f_row;
    t_job_flags                     f_flags;

    // Job at the head of the queue, as seen by the back.
    logic                           q_valid;
    logic [QW-1:0]                  q_data;
    logic [QLW-1:0]                 q_level;
    logic                           q_pop;
    logic [NPX-1:0][PIXEL_BITS-1:0] b_px;
    logic [CW-1:0]                  b_col;
    logic [ROW_W-1:0]               b_row;
    t_job_flags                     b_flags;

    // Front: count positions, read and update the line stores, classify the pixel.
    s2x_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_pixel     (i_pixel),
        .o_stall     (o_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_q_level   (q_level),
        .o_job_valid (f_valid),
        .o_job_px    (f_px),
        .o_job_col   (f_col),
        .o_job_row   (f_row),
        .o_job_flags (f_flags)
    );

    // Queue: decouple pixel intake from block delivery.
    s2x_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_px, f_col, f_row, f_flags}),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_level (q_level)
    );

    assign b_px    = q_data[QW-1 -: PXW];
    assign b_col   = q_data[ROW_W+FW +: CW];
    assign b_row   = q_data[FW +: ROW_W];
    assign b_flags = t_job_flags'(q_data[FW-1:0]);

    // Back: emit the blocks of the head job in order, one per clock while i_stall is low.
    s2x_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job_px       (b_px),
        .i_job_col      (b_col),
        .i_job_row      (b_row),
        .i_job_flags    (b_flags),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_top_left     (o_top_left),
        .o_top_right    (o_top_right),
        .o_bottom_left  (o_bottom_left),
        .o_bottom_right (o_bottom_right),
        .o_out_col      (o_out_col),
        .o_out_row      (o_out_row),
        .o_last_of_run  (o_last_of_run),
        .o_frame_done   (o_frame_done)
    );

endmodule

FILE: hw/rtl/s2x_checker.sv
// Port checks of the 2x pixel upscaler and their binding to the top level.
`timescale 1ns / 1ps

module s2x_checker import s2x_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [PORT_PIX_W-1:0] o_top_left,
    input logic [COL_PORT_W-1:0] o_out_col,
    input logic                  o_last_of_run,
    input logic                  o_frame_done
);

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

    // The frame's final block closes the run of its pixel.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_done |-> o_last_of_run)
        else $error("frame end without end of run");

    // Blocks of one pixel leave without gaps.
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_run |=> o_valid)
        else $error("gap inside a run of blocks");

    // Hold a stalled word.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_top_left) && $stable(o_out_col)
            && $stable(o_last_of_run))
        else $error("stalled output word changed");

endmodule

bind scale2x_pixel_upscaler s2x_checker u_s2x_checker (.*);
